/* rtl/core/mmbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmbd_pkg
// Shared constants and types of the min/max bucket decimator.
// ----------------------------------------------------------------------------
package mmbd_pkg;

  // Default sizing of the block.
  localparam int DEF_SAMPLE_WIDTH = 24;
  localparam int DEF_MAX_WINDOW   = 1048576;
  localparam int DEF_MAX_BUCKETS  = 4096;

  // Configuration register widths and indexes.
  localparam int CFG_COUNT_WIDTH   = 21;
  localparam int CFG_BUCKETS_WIDTH = 13;
  localparam int CFG_OFFSET_WIDTH  = 21;
  localparam int CFG_DATA_WIDTH    = 21;
  localparam int CFG_INDEX_WIDTH   = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SAMPLE_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BUCKET_COUNT    = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POSITION_OFFSET = 2'd2;

  localparam logic [CFG_COUNT_WIDTH-1:0]   RST_SAMPLE_COUNT    = 21'd1;
  localparam logic [CFG_BUCKETS_WIDTH-1:0] RST_BUCKET_COUNT    = 13'd64;
  localparam logic [CFG_OFFSET_WIDTH-1:0]  RST_POSITION_OFFSET = 21'd0;

  // Width of an emitted timeline position; sums wrap at this width.
  localparam int POS_WIDTH = 22;

  // Everything about an emitted point except its sample value.
  typedef struct packed {
    logic [POS_WIDTH-1:0] position;
    logic                 is_max;
    logic                 run_last;
    logic                 frame_last;
  } point_meta_t;

  // A closed bucket: no, one or two points, in time order.
  typedef struct packed {
    logic        valid;
    logic        two;
    point_meta_t first;
    point_meta_t second;
  } bucket_event_t;

endpackage

/* rtl/core/mmbd_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmbd_tracker
// Window position, bucket boundary and running min/max of the open bucket.
// ----------------------------------------------------------------------------
module mmbd_tracker #(
  parameter int SAMPLE_WIDTH = mmbd_pkg::DEF_SAMPLE_WIDTH,
  parameter int MAX_WINDOW   = mmbd_pkg::DEF_MAX_WINDOW,
  parameter int MAX_BUCKETS  = mmbd_pkg::DEF_MAX_BUCKETS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   restart,
  input  logic [mmbd_pkg::CFG_COUNT_WIDTH-1:0]   sample_count,
  input  logic [mmbd_pkg::CFG_BUCKETS_WIDTH-1:0] bucket_count,
  input  logic [mmbd_pkg::CFG_OFFSET_WIDTH-1:0]  position_offset,
  input  logic                                   accept,
  input  logic signed [SAMPLE_WIDTH-1:0]         sample_value,
  input  logic                                   sample_valid,
  output mmbd_pkg::bucket_event_t                close_event,
  output logic signed [SAMPLE_WIDTH-1:0]         first_value,
  output logic signed [SAMPLE_WIDTH-1:0]         second_value
);

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int BW = $clog2(MAX_BUCKETS + 1);
  localparam int SW = ((CW > BW) ? CW : BW) + 1;
  localparam int PW = mmbd_pkg::POS_WIDTH;

  logic [CW-1:0]                 window_index;
  logic [CW-1:0]                 boundary_error;
  logic                          have_extreme;
  logic signed [SAMPLE_WIDTH-1:0] min_value;
  logic signed [SAMPLE_WIDTH-1:0] max_value;
  logic [CW-1:0]                 min_position;
  logic [CW-1:0]                 max_position;

  logic [31:0]                   count_wide;
  logic [31:0]                   buckets_wide;
  logic [CW-1:0]                 eff_count;
  logic [BW-1:0]                 eff_buckets;
  logic [SW-1:0]                 err_cur;
  logic [SW-1:0]                 err_sum;
  logic                          wide_buckets;
  logic                          bucket_close;
  logic                          frame_end;
  logic                          take_min;
  logic                          take_max;
  logic                          have_next;
  logic signed [SAMPLE_WIDTH-1:0] min_next;
  logic signed [SAMPLE_WIDTH-1:0] max_next;
  logic [CW-1:0]                 min_pos_next;
  logic [CW-1:0]                 max_pos_next;
  mmbd_pkg::point_meta_t         min_meta;
  mmbd_pkg::point_meta_t         max_meta;

  // Effective register values: zero acts as one, large values saturate.
  always_comb begin
    count_wide   = 32'(sample_count);
    buckets_wide = 32'(bucket_count);
    if (count_wide == 32'd0) begin
      eff_count = CW'(1);
    end else if (count_wide > 32'(MAX_WINDOW)) begin
      eff_count = CW'(MAX_WINDOW);
    end else begin
      eff_count = CW'(count_wide);
    end
    if (buckets_wide == 32'd0) begin
      eff_buckets = BW'(1);
    end else if (buckets_wide > 32'(MAX_BUCKETS)) begin
      eff_buckets = BW'(MAX_BUCKETS);
    end else begin
      eff_buckets = BW'(buckets_wide);
    end
  end

  // The boundary error is ((i+1)*buckets - 1) mod count. Sample i closes its
  // bucket when error + buckets reaches count. With at least as many buckets
  // as samples every sample closes one, and the error is not needed.
  always_comb begin
    err_cur      = (window_index == '0) ? SW'(eff_buckets) - SW'(1)
                                        : SW'(boundary_error);
    err_sum      = err_cur + SW'(eff_buckets);
    wide_buckets = SW'(eff_buckets) >= SW'(eff_count);
    bucket_close = wide_buckets || (err_sum >= SW'(eff_count));
    frame_end    = window_index == (eff_count - CW'(1));
  end

  // Running extremes including the current sample.
  always_comb begin
    take_min     = sample_valid && (!have_extreme || (sample_value < min_value));
    take_max     = sample_valid && (!have_extreme || (sample_value > max_value));
    min_next     = take_min ? sample_value : min_value;
    max_next     = take_max ? sample_value : max_value;
    min_pos_next = take_min ? window_index : min_position;
    max_pos_next = take_max ? window_index : max_position;
    have_next    = have_extreme || sample_valid;
  end

  // Closed bucket: points in time order, minimum alone when both coincide.
  always_comb begin
    min_meta.position   = PW'(position_offset) + PW'(min_pos_next);
    min_meta.is_max     = 1'b0;
    min_meta.run_last   = 1'b0;
    min_meta.frame_last = frame_end;
    max_meta.position   = PW'(position_offset) + PW'(max_pos_next);
    max_meta.is_max     = 1'b1;
    max_meta.run_last   = 1'b0;
    max_meta.frame_last = frame_end;

    close_event.valid = bucket_close && have_next;
    close_event.two   = min_pos_next != max_pos_next;
    if (!close_event.two || (min_pos_next < max_pos_next)) begin
      close_event.first  = min_meta;
      close_event.second = max_meta;
      first_value        = min_next;
      second_value       = max_next;
    end else begin
      close_event.first  = max_meta;
      close_event.second = min_meta;
      first_value        = max_next;
      second_value       = min_next;
    end
    close_event.first.run_last  = !close_event.two;
    close_event.second.run_last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      window_index   <= '0;
      boundary_error <= '0;
      have_extreme   <= 1'b0;
      min_value      <= '0;
      max_value      <= '0;
      min_position   <= '0;
      max_position   <= '0;
    end else if (accept) begin
      window_index   <= frame_end ? '0 : window_index + CW'(1);
      boundary_error <= bucket_close ? CW'(err_sum - SW'(eff_count)) : CW'(err_sum);
      if (bucket_close) begin
        have_extreme <= 1'b0;
        min_value    <= '0;
        max_value    <= '0;
        min_position <= '0;
        max_position <= '0;
      end else begin
        have_extreme <= have_next;
        min_value    <= min_next;
        max_value    <= max_next;
        min_position <= min_pos_next;
        max_position <= max_pos_next;
      end
    end
  end

endmodule

/* rtl/core/mmbd_emitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmbd_emitter
// Holds one closed bucket and sends its points out one word at a time.
// ----------------------------------------------------------------------------
module mmbd_emitter #(
  parameter int SAMPLE_WIDTH = mmbd_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  mmbd_pkg::bucket_event_t        close_event,
  input  logic signed [SAMPLE_WIDTH-1:0] first_value,
  input  logic signed [SAMPLE_WIDTH-1:0] second_value,
  output logic                           push_stall,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mmbd_pkg::point_meta_t          out_meta,
  output logic signed [SAMPLE_WIDTH-1:0] out_value
);

  logic                           ev_valid;
  logic                           ev_two;
  mmbd_pkg::point_meta_t          ev_meta_a;
  mmbd_pkg::point_meta_t          ev_meta_b;
  logic signed [SAMPLE_WIDTH-1:0] ev_value_a;
  logic signed [SAMPLE_WIDTH-1:0] ev_value_b;
  logic                           out_free;
  logic                           ev_shift;
  logic                           ev_load;

  assign out_free   = !out_valid || !out_stall;
  assign ev_shift   = out_free && ev_valid && ev_two;
  // A new bucket may enter when the held one leaves in this cycle.
  assign push_stall = ev_valid && !(out_free && !ev_two);
  assign ev_load    = push && close_event.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid  <= 1'b0;
      ev_two    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= ev_valid;
      end
      if (ev_load) begin
        ev_valid <= 1'b1;
        ev_two   <= close_event.two;
      end else if (ev_shift) begin
        ev_two <= 1'b0;
      end else if (out_free) begin
        ev_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && ev_valid) begin
      out_meta  <= ev_meta_a;
      out_value <= ev_value_a;
    end
    if (ev_load) begin
      ev_meta_a  <= close_event.first;
      ev_meta_b  <= close_event.second;
      ev_value_a <= first_value;
      ev_value_b <= second_value;
    end else if (ev_shift) begin
      ev_meta_a  <= ev_meta_b;
      ev_value_a <= ev_value_b;
    end
  end

endmodule

/* rtl/core/min_max_bucket_decimator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_bucket_decimator
// Min/max decimation of a sample window into display buckets.
// ----------------------------------------------------------------------------
//
// Channel   Signals                               Direction  Word
// input     in_valid, in_stall, sample_*          in         one sample
// output    out_valid, out_stall, point_*, *_last out        one extreme point
// config    write_enable, write_index, write_data in         one register
//
// One sample is taken every cycle while in_stall is low. A bucket whose
// minimum and maximum are different samples gives two words; the second
// one holds the input back until it is sent, as the output port allows.
// Reset (rst, synchronous) restores the register defaults and starts a new
// frame at window position zero. Any write to a known register also
// restarts the frame and drops the extremes of the open bucket.
// The input stalls only while a closed bucket waits for the output side.
//
// The tracker keeps the window index and the remainder of the exact
// integer bucket boundary, so no divider is needed: each sample adds the
// bucket count to the remainder and compares it with the sample count.
// The first strict minimum and maximum of each bucket are kept; gaps
// (sample_valid low) do not take part. When a bucket closes, its points
// pass through a one-bucket holding stage and an output register, in time
// order, and are positioned at position_offset plus the window index.
module min_max_bucket_decimator #(
  parameter int SAMPLE_WIDTH = mmbd_pkg::DEF_SAMPLE_WIDTH,
  parameter int MAX_WINDOW   = mmbd_pkg::DEF_MAX_WINDOW,
  parameter int MAX_BUCKETS  = mmbd_pkg::DEF_MAX_BUCKETS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port.
  input  logic                                 write_enable,
  input  logic [mmbd_pkg::CFG_INDEX_WIDTH-1:0] write_index,
  input  logic [mmbd_pkg::CFG_DATA_WIDTH-1:0]  write_data,
  // Sample input.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_value,
  input  logic                                 sample_valid,
  // Point output.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mmbd_pkg::POS_WIDTH-1:0]       point_position,
  output logic signed [SAMPLE_WIDTH-1:0]       point_value,
  output logic                                 point_is_max,
  output logic                                 run_last,
  output logic                                 frame_last
);

  logic [mmbd_pkg::CFG_COUNT_WIDTH-1:0]   sample_count;
  logic [mmbd_pkg::CFG_BUCKETS_WIDTH-1:0] bucket_count;
  logic [mmbd_pkg::CFG_OFFSET_WIDTH-1:0]  position_offset;
  logic                                   restart;
  logic                                   accept;
  mmbd_pkg::bucket_event_t                close_event;
  logic signed [SAMPLE_WIDTH-1:0]         first_value;
  logic signed [SAMPLE_WIDTH-1:0]         second_value;
  mmbd_pkg::point_meta_t                  out_meta;

  // Writes to an index beyond the register list are ignored entirely.
  always_comb begin
    unique case (write_index)
      mmbd_pkg::CFG_SAMPLE_COUNT,
      mmbd_pkg::CFG_BUCKET_COUNT,
      mmbd_pkg::CFG_POSITION_OFFSET: restart = write_enable;
      default:                       restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count    <= mmbd_pkg::RST_SAMPLE_COUNT;
      bucket_count    <= mmbd_pkg::RST_BUCKET_COUNT;
      position_offset <= mmbd_pkg::RST_POSITION_OFFSET;
    end else if (write_enable) begin
      unique case (write_index)
        mmbd_pkg::CFG_SAMPLE_COUNT: begin
          sample_count <= mmbd_pkg::CFG_COUNT_WIDTH'(write_data);
        end
        mmbd_pkg::CFG_BUCKET_COUNT: begin
          bucket_count <= mmbd_pkg::CFG_BUCKETS_WIDTH'(write_data);
        end
        mmbd_pkg::CFG_POSITION_OFFSET: begin
          position_offset <= mmbd_pkg::CFG_OFFSET_WIDTH'(write_data);
        end
        default: begin
        end
      endcase
    end
  end

  assign accept = in_valid && !in_stall;

  mmbd_tracker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .MAX_WINDOW   (MAX_WINDOW),
    .MAX_BUCKETS  (MAX_BUCKETS)
  ) u_tracker (
    .clk             (clk),
    .rst             (rst),
    .restart         (restart),
    .sample_count    (sample_count),
    .bucket_count    (bucket_count),
    .position_offset (position_offset),
    .accept          (accept),
    .sample_value    (sample_value),
    .sample_valid    (sample_valid),
    .close_event     (close_event),
    .first_value     (first_value),
    .second_value    (second_value)
  );

  mmbd_emitter #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_emitter (
    .clk          (clk),
    .rst          (rst),
    .push         (accept),
    .close_event  (close_event),
    .first_value  (first_value),
    .second_value (second_value),
    .push_stall   (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_meta     (out_meta),
    .out_value    (point_value)
  );

  assign point_position = out_meta.position;
  assign point_is_max   = out_meta.is_max;
  assign run_last       = out_meta.run_last;
  assign frame_last     = out_meta.frame_last;

endmodule
